// ===== src/swera_pkg.sv =====
// Shared constants and types for the sliding-window event rate alarm.
package swera_pkg;

   localparam int DEPTH_DEFAULT = 128;

   // Wide enough for a count of up to 1024 held stamps.
   localparam int CNT_W = 11;

   localparam int STAMP_W  = 32;
   localparam int THRESH_W = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALARM_THRESHOLD = 1'd1;

   localparam logic [STAMP_W-1:0]  WINDOW_RESET = 32'd3600;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd5;

   // Token that walks the cell chain, one cell per cycle, for one request.
   typedef struct packed {
      logic             active;
      logic             placed;
      logic [CNT_W-1:0] count;
   } token_type;

endpackage

// ===== src/swera_cell.sv =====
// One storage cell of the chain: a single stamp slot with expiry and insertion.
module swera_cell
   import swera_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [STAMP_W-1:0] now,
   input  logic [STAMP_W-1:0] window,
   input  token_type          tok_in,
   output token_type          tok_out
);

   logic               valid_ff, valid_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   token_type          tok_ff, tok_in_next;

   logic [STAMP_W:0] age;
   logic             expired;
   logic             live;
   logic             take;

   // A negative age (stamp in the future) never expires the slot.
   assign age     = {1'b0, now} - {1'b0, stamp_ff};
   assign expired = !age[STAMP_W] && (age[STAMP_W-1:0] > window);
   assign live    = valid_ff && !expired;
   assign take    = tok_in.active && !live && !tok_in.placed;

   always_comb begin
      valid_in = valid_ff;
      stamp_in = stamp_ff;
      if (tok_in.active) begin
         valid_in = live || take;
      end
      if (take) begin
         stamp_in = now;
      end
      tok_in_next.active = tok_in.active;
      tok_in_next.placed = tok_in.placed || take;
      tok_in_next.count  = tok_in.count + CNT_W'(live || take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/sliding_window_event_rate_alarm.sv =====
// Top level of the sliding-window event rate alarm: control, registers and cell chain.
//
// Each request carries one event timestamp in seconds (req_event_time). The block
// holds up to DEPTH earlier stamps, one per cell of a chain. A request sends a token
// down the chain, one cell per cycle; each cell expires its stamp if its age is above
// window_seconds, and the first free cell the token meets takes the new stamp. The
// token counts the surviving stamps on its way.
// One response follows each request: the held count (low 8 bits), an alarm bit that
// is set when the count is at or above alarm_threshold, and a drop flag when all
// slots were taken.
// Each request passes through the inject register, the DEPTH cell registers, the
// holding stage and the output register in that order; the block takes no new
// request until the result of the last one has left the holding stage.
// A finished result waits in an output register; the next request is already
// accepted while it waits. If the receiver holds rsp_ready low, the next result
// parks in a holding stage and no further request is taken until it moves on.
// Reset clears all valid bits and the held count, and loads window_seconds = 3600
// and alarm_threshold = 5. The user must write registers through the csr_ port only
// while idle, not enforced by the block; csr_ready is always high, every index exists.
module sliding_window_event_rate_alarm
   import swera_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [STAMP_W-1:0]   req_event_time,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_alarm,
   output logic [7:0]           rsp_window_count,
   output logic                 rsp_store_full_drop,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [STAMP_W-1:0]   csr_wdata
);

   logic [STAMP_W-1:0]  window_ff, window_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [STAMP_W-1:0]  now_ff, now_in;
   logic                busy_ff, busy_in;
   logic                inject_ff;
   logic                pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]    pend_count_ff, pend_count_in;
   logic                pend_drop_ff, pend_drop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_alarm_ff, rsp_alarm_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_drop_ff, rsp_drop_in;

   logic      accept;
   logic      rsp_load;
   token_type tok [DEPTH+1];
   token_type tok_end;

   assign req_ready = !busy_ff;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // Configuration registers.
   always_comb begin
      window_in = window_ff;
      thresh_in = thresh_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_SECONDS:  window_in = csr_wdata;
            CSR_ALARM_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // The token enters cell 0 in the cycle after acceptance, once the stamp is latched.
   assign tok[0] = '{active: inject_ff, placed: 1'b0, count: '0};

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      swera_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .now    (now_ff),
         .window (window_ff),
         .tok_in (tok[g]),
         .tok_out(tok[g+1])
      );
   end

   assign tok_end = tok[DEPTH];

   assign rsp_load = pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      now_in        = accept ? req_event_time : now_ff;
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      pend_count_in = pend_count_ff;
      pend_drop_in  = pend_drop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_alarm_in  = rsp_alarm_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_drop_in   = rsp_drop_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (tok_end.active) begin
         pend_valid_in = 1'b1;
         pend_count_in = tok_end.count;
         pend_drop_in  = !tok_end.placed;
      end
      if (rsp_load) begin
         pend_valid_in = 1'b0;
         busy_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_count_in  = pend_count_ff;
         rsp_drop_in   = pend_drop_ff;
         rsp_alarm_in  = pend_count_ff >= CNT_W'(thresh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= WINDOW_RESET;
         thresh_ff     <= THRESH_RESET;
         busy_ff       <= 1'b0;
         inject_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_ff     <= window_in;
         thresh_ff     <= thresh_in;
         busy_ff       <= busy_in;
         inject_ff     <= accept;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      pend_count_ff <= pend_count_in;
      pend_drop_ff  <= pend_drop_in;
      rsp_alarm_ff  <= rsp_alarm_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_alarm           = rsp_alarm_ff;
   assign rsp_window_count    = rsp_count_ff[7:0];
   assign rsp_store_full_drop = rsp_drop_ff;

   // A token only walks the chain while a request is in progress.
   a_token_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (tok_end.active || inject_ff) |-> busy_ff)
      else $error("token in chain while block idle");

   // The holding stage never gets a second result on top of an unsent one.
   a_no_pend_overrun: assert property (@(posedge clock) disable iff (reset)
      tok_end.active |-> !pend_valid_ff)
      else $error("result arrived while holding stage was occupied");

   // A finished count never exceeds the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      tok_end.active |-> (tok_end.count <= CNT_W'(DEPTH)))
      else $error("count above DEPTH");

   // A drop is only possible when every slot is held.
   a_drop_means_full: assert property (@(posedge clock) disable iff (reset)
      (tok_end.active && !tok_end.placed) |-> (tok_end.count == CNT_W'(DEPTH)))
      else $error("stamp dropped with free slots left");

endmodule

// ===== tb/tb_sliding_window_event_rate_alarm.sv =====
// Self-checking testbench for the sliding-window event rate alarm.
module tb_sliding_window_event_rate_alarm
   import swera_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int STUCK_LIMIT = 20000;
   localparam int PHASE_ITEMS = 80;

   typedef struct packed {
      logic       alarm;
      logic [7:0] window_count;
      logic       store_full_drop;
   } rate_report_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [STAMP_W-1:0]   req_event_time;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_alarm;
   logic [7:0]           rsp_window_count;
   logic                 rsp_store_full_drop;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [STAMP_W-1:0]   csr_wdata;

   // Shadow copy of the block's stamp store and registers.
   logic [STAMP_W-1:0]  shadow_stamp [DEPTH];
   bit                  shadow_used  [DEPTH];
   logic [STAMP_W-1:0]  window_setting;
   logic [THRESH_W-1:0] threshold_setting;

   rate_report_type expected_reports[$];
   int              mismatch_count = 0;
   int              stuck_cycles   = 0;
   int              stall_left     = 0;
   bit              idle_on        = 1'b1;

   sliding_window_event_rate_alarm i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_event_time      (req_event_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_alarm           (rsp_alarm),
      .rsp_window_count    (rsp_window_count),
      .rsp_store_full_drop (rsp_store_full_drop),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(20, 200);
   endfunction

   // Expire old stamps, place the new one in the first free slot and report.
   function automatic rate_report_type predict_rate(input logic [STAMP_W-1:0] now);
      rate_report_type report;
      int              free_idx;
      int unsigned     held;
      longint          age;
      int              i;
      free_idx = -1;
      held     = 0;
      for (i = 0; i < DEPTH; i++) begin
         if (shadow_used[i]) begin
            age = $signed({32'd0, now}) - $signed({32'd0, shadow_stamp[i]});
            if (age > $signed({32'd0, window_setting})) begin
               shadow_used[i] = 1'b0;
            end else begin
               held++;
            end
         end
         if (!shadow_used[i] && free_idx < 0) free_idx = i;
      end
      report.store_full_drop = (free_idx < 0);
      if (free_idx >= 0) begin
         shadow_stamp[free_idx] = now;
         shadow_used[free_idx]  = 1'b1;
         held++;
      end
      report.window_count = held[7:0];
      report.alarm        = (held >= threshold_setting);
      return report;
   endfunction

   task automatic send_event(input logic [STAMP_W-1:0] stamp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_event_time <= stamp;
      do @(posedge clock); while (!req_ready);
      expected_reports.push_back(predict_rate(stamp));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [STAMP_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_WINDOW_SECONDS:  window_setting    = value;
         CSR_ALARM_THRESHOLD: threshold_setting = value[THRESH_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drains every outstanding request and lets the cell chain settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
   endtask

   task automatic test_directed_extremes();
      send_event(32'h0000_0000);
      send_event(32'hFFFF_FFFF);
      send_event(32'h0000_0000);
      send_event(32'd3600);
      send_event(32'd3601);
      send_event(32'h8000_0000);
      send_event(32'h7FFF_FFFF);
      send_event(32'h5555_5555);
      send_event(32'hAAAA_AAAA);
      send_event(32'hAAAA_AAAA);
   endtask

   task automatic test_config_specials();
      wait_idle();
      // A zero threshold raises the alarm on every request.
      write_reg(CSR_WINDOW_SECONDS, 32'd0);
      write_reg(CSR_ALARM_THRESHOLD, 32'd0);
      send_event(32'd1000);
      send_event(32'd1000);
      send_event(32'd999);
      send_event(32'd1001);
      send_event(32'd1001);
      wait_idle();
      // A threshold above the store size can never be reached.
      write_reg(CSR_WINDOW_SECONDS, 32'hFFFF_FFFF);
      write_reg(CSR_ALARM_THRESHOLD, 32'd255);
      send_event(32'h0000_0000);
      send_event(32'hFFFF_FFFF);
      wait_idle();
      write_reg(CSR_ALARM_THRESHOLD, 32'd129);
      send_event(32'h1234_5678);
      send_event(32'h0000_0001);
   endtask

   task automatic test_store_full();
      int n;
      wait_idle();
      write_reg(CSR_WINDOW_SECONDS, 32'hFFFF_FFFF);
      write_reg(CSR_ALARM_THRESHOLD, 32'd128);
      for (n = 0; n < DEPTH + 6; n++) send_event($urandom);
      wait_idle();
      // Only stamps at the very top survive a zero window at the top time.
      write_reg(CSR_WINDOW_SECONDS, 32'd0);
      send_event(32'hFFFF_FFFF);
      send_event(32'h0000_0000);
   endtask

   task automatic test_random_traffic();
      logic [STAMP_W-1:0] cursor;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] win;
      logic [7:0]         thr;
      int                 phase;
      int                 n;
      int                 roll;
      for (phase = 0; phase < 7; phase++) begin
         wait_idle();
         idle_on = (phase != 3);
         case (phase % 5)
            0:       win = 32'd0;
            1:       win = $urandom_range(1, 20);
            2:       win = $urandom_range(40, 250);
            3:       win = 32'hFFFF_FFFF;
            default: win = $urandom;
         endcase
         case (phase % 4)
            0:       thr = 8'd0;
            1:       thr = 8'd128;
            2:       thr = 8'($urandom_range(129, 255));
            default: thr = 8'($urandom_range(1, 127));
         endcase
         write_reg(CSR_WINDOW_SECONDS, win);
         // Upper data bits are don't-care for the threshold register.
         write_reg(CSR_ALARM_THRESHOLD, {24'($urandom_range(0, 32'hFF_FFFF)), thr});
         cursor = (phase == 1) ? 32'hFFFF_FFC0 + $urandom_range(0, 31) : $urandom;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
               cursor = cursor + $urandom_range(0, 2);
               stamp  = cursor + $urandom_range(0, 6) - 32'd3;
            end else if (roll < 95) begin
               stamp = $urandom;
            end else begin
               cursor = cursor + $urandom;
               stamp  = cursor;
            end
            send_event(stamp);
         end
      end
      idle_on = 1'b1;
   endtask

   // Response side: random back-pressure.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      rate_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_alarm !== want.alarm) begin
               $error("alarm: expected %0d, got %0d", want.alarm, rsp_alarm);
               mismatch_count++;
            end
            if (rsp_window_count !== want.window_count) begin
               $error("window_count: expected %0d, got %0d",
                      want.window_count, rsp_window_count);
               mismatch_count++;
            end
            if (rsp_store_full_drop !== want.store_full_drop) begin
               $error("store_full_drop: expected %0d, got %0d",
                      want.store_full_drop, rsp_store_full_drop);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_event_time = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_WINDOW_SECONDS;
      csr_wdata      = '0;
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      window_setting    = WINDOW_RESET;
      threshold_setting = THRESH_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_extremes();
      test_config_specials();
      test_store_full();
      test_random_traffic();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
